/* rtl/core/lcp_pkg.sv */
// ----------------------------------------------------------------------------
// Line command parser package
// Shared item types, event codes, character codes and command text constants.
// ----------------------------------------------------------------------------
package lcp_pkg;

  // Line buffer geometry.
  localparam int unsigned MAX_LINE = 64;
  localparam int unsigned ADDR_W   = $clog2(MAX_LINE);
  localparam int unsigned CNT_W    = $clog2(MAX_LINE + 1);

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Event codes.
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_HELP      = 4'd1;
  localparam logic [3:0] EV_STATUS    = 4'd2;
  localparam logic [3:0] EV_LED       = 4'd3;
  localparam logic [3:0] EV_RATE      = 4'd4;
  localparam logic [3:0] EV_MALFORMED = 4'd5;
  localparam logic [3:0] EV_UNKNOWN   = 4'd6;
  localparam logic [3:0] EV_TOO_LONG  = 4'd7;
  localparam logic [3:0] EV_TIMEOUT   = 4'd8;

  // LED action codes.
  localparam logic [1:0] LED_NONE   = 2'd0;
  localparam logic [1:0] LED_ON     = 2'd1;
  localparam logic [1:0] LED_OFF    = 2'd2;
  localparam logic [1:0] LED_TOGGLE = 2'd3;

  // Character codes.
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  // Rate limits.
  localparam logic [16:0] RATE_MAX   = 17'd10000;
  localparam int unsigned RATE_FIRST = 5;

  // Command texts, left aligned in a ten-character field.
  localparam int unsigned NPAT    = 9;
  localparam int unsigned PAT_MAX = 10;

  localparam int unsigned P_HELP    = 0;
  localparam int unsigned P_STATUS  = 1;
  localparam int unsigned P_LED_ON  = 2;
  localparam int unsigned P_LED_OFF = 3;
  localparam int unsigned P_LED_TOG = 4;
  localparam int unsigned P_LED     = 5;
  localparam int unsigned P_LED_SP  = 6;
  localparam int unsigned P_RATE    = 7;
  localparam int unsigned P_RATE_SP = 8;

  localparam logic [8*PAT_MAX-1:0] PAT_TEXT [NPAT] = '{
    {"help", 48'h0},
    {"status", 32'h0},
    {"led on", 32'h0},
    {"led off", 24'h0},
    "led toggle",
    {"led", 56'h0},
    {"led ", 48'h0},
    {"rate", 48'h0},
    {"rate ", 40'h0}
  };

  localparam int unsigned PAT_LEN [NPAT] = '{4, 6, 6, 7, 10, 3, 4, 4, 5};

  // One input item.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [31:0] rx_tick;
  } lcp_in_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  event_res;
    logic [1:0]  led_cmd;
    logic [13:0] rate_value;
  } lcp_out_t;

endpackage

/* rtl/core/line_command_parser.sv */
// ----------------------------------------------------------------------------
// Line command parser
// Buffers received bytes into a line and decodes each finished line that is neither
// empty nor too long into one command event; timeout polls drop a line that has gone silent.
// ----------------------------------------------------------------------------
// A byte or poll item is handled in EXEC, then waits in OUT for the output
// register; a line feed that decodes a stored line first walks the line buffer
// in RD and CMP, a read and a compare per byte, then sets the event in FIN.
// Items are taken one at a time; the next item is accepted once the current
// one has been handed to the output register.
// Reset (rst, synchronous, active high) clears the line state, the timeout
// register and the output valid; the line buffer itself is not cleared.
// ----------------------------------------------------------------------------
module line_command_parser (
  input  logic              clk,
  input  logic              rst,
  // Input item channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  lcp_pkg::lcp_in_t  in_item,
  // Result item channel.
  output logic              out_valid,
  input  logic              out_ready,
  output lcp_pkg::lcp_out_t out_item,
  // Timeout register write port.
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  // Sequencer states. IDLE takes an item, EXEC handles everything but the
  // line decode, RD and CMP alternate over the stored bytes, FIN turns the
  // match flags into an event, and OUT waits for the output register.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state, state_next;

  // Configuration.
  logic [31:0] timeout_limit;

  // Line state.
  logic [lcp_pkg::CNT_W-1:0] line_count, line_count_next;
  logic [31:0]               last_tick, last_tick_next;
  logic                      active_flag, active_flag_next;
  logic                      discard_flag, discard_flag_next;

  // Current item and pending result.
  lcp_pkg::lcp_in_t  cur;
  lcp_pkg::lcp_out_t res, res_next;

  // Decode walk state: position, one match flag per command text, and the
  // running rate value with its validity.
  logic [lcp_pkg::CNT_W-1:0] idx, idx_next;
  logic [lcp_pkg::NPAT-1:0]  match, match_next;
  logic [13:0]               rate_val, rate_val_next;
  logic                      rate_ok, rate_ok_next;

  // Line buffer ports.
  logic                       ram_we;
  logic [lcp_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_rdata;

  // Helpers.
  logic [31:0] elapsed;
  logic        poll_hit;
  logic [16:0] rate_acc;
  logic        is_digit;
  logic [lcp_pkg::NPAT-1:0] exact_hit;
  logic [lcp_pkg::NPAT-1:0] prefix_hit;

  assign in_ready = (state == ST_IDLE);
  assign ram_waddr = line_count[lcp_pkg::ADDR_W-1:0];

  // The single wide subtract and compare used by timeout polls.
  assign elapsed  = cur.rx_tick - last_tick;
  assign poll_hit = active_flag && (timeout_limit != 32'd0) && (elapsed >= timeout_limit);

  // Decimal accumulate: value times ten (shift and add) plus the new digit.
  assign is_digit = (ram_rdata >= lcp_pkg::CHAR_0) && (ram_rdata <= lcp_pkg::CHAR_9);
  assign rate_acc = ({3'b000, rate_val} << 3) + ({3'b000, rate_val} << 1)
                  + {9'd0, ram_rdata - lcp_pkg::CHAR_0};

  // The decoded length is the walk position when the walk ends.
  always_comb begin
    for (int k = 0; k < lcp_pkg::NPAT; k++) begin
      exact_hit[k]  = match[k] && (idx == lcp_pkg::CNT_W'(lcp_pkg::PAT_LEN[k]));
      prefix_hit[k] = match[k] && (idx >= lcp_pkg::CNT_W'(lcp_pkg::PAT_LEN[k]));
    end
  end

  lcp_ram #(
    .WIDTH(8),
    .DEPTH(lcp_pkg::MAX_LINE)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cur.data_byte),
    .raddr(idx[lcp_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next        = state;
    line_count_next   = line_count;
    last_tick_next    = last_tick;
    active_flag_next  = active_flag;
    discard_flag_next = discard_flag;
    res_next          = res;
    idx_next          = idx;
    match_next        = match;
    rate_val_next     = rate_val;
    rate_ok_next      = rate_ok;
    ram_we            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_next   = '{event_res: lcp_pkg::EV_NONE, led_cmd: lcp_pkg::LED_NONE,
                       rate_value: 14'd0};
        state_next = ST_OUT;
        if (cur.op == lcp_pkg::OP_POLL) begin
          if (poll_hit) begin
            line_count_next     = '0;
            active_flag_next    = 1'b0;
            discard_flag_next   = 1'b0;
            res_next.event_res  = lcp_pkg::EV_TIMEOUT;
          end
        end else if (cur.data_byte == lcp_pkg::CHAR_CR) begin
          // A carriage return is never stored; it only keeps a line alive.
          if (active_flag) begin
            last_tick_next = cur.rx_tick;
          end
        end else if (cur.data_byte == lcp_pkg::CHAR_LF) begin
          if (discard_flag) begin
            line_count_next   = '0;
            active_flag_next  = 1'b0;
            discard_flag_next = 1'b0;
          end else if (line_count == '0) begin
            active_flag_next = 1'b0;
          end else begin
            // Start the walk over the stored line.
            idx_next      = '0;
            match_next    = '1;
            rate_val_next = 14'd0;
            rate_ok_next  = 1'b1;
            state_next    = ST_RD;
          end
        end else if (discard_flag) begin
          last_tick_next = cur.rx_tick;
        end else if (line_count >= lcp_pkg::CNT_W'(lcp_pkg::MAX_LINE)) begin
          // The buffer is full: report once, then skip up to the line feed.
          discard_flag_next  = 1'b1;
          active_flag_next   = 1'b1;
          last_tick_next     = cur.rx_tick;
          res_next.event_res = lcp_pkg::EV_TOO_LONG;
        end else begin
          ram_we           = 1'b1;
          line_count_next  = line_count + 1'b1;
          active_flag_next = 1'b1;
          last_tick_next   = cur.rx_tick;
        end
      end

      ST_RD: begin
        // The walk ends at the stored length; the read is issued otherwise.
        if (idx == line_count) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_CMP;
        end
      end

      ST_CMP: begin
        if (ram_rdata == lcp_pkg::CHAR_NUL) begin
          // A zero byte cuts the text short.
          state_next = ST_FIN;
        end else begin
          // Each command text drops out at its first differing character.
          for (int k = 0; k < lcp_pkg::NPAT; k++) begin
            for (int j = 0; j < lcp_pkg::PAT_MAX; j++) begin
              if ((j < lcp_pkg::PAT_LEN[k]) && (idx == lcp_pkg::CNT_W'(j)) &&
                  (ram_rdata != lcp_pkg::PAT_TEXT[k][8*lcp_pkg::PAT_MAX-1-8*j -: 8])) begin
                match_next[k] = 1'b0;
              end
            end
          end
          // Digits of a rate command start after "rate ".
          if (idx >= lcp_pkg::CNT_W'(lcp_pkg::RATE_FIRST)) begin
            if (!is_digit) begin
              rate_ok_next = 1'b0;
            end else if (rate_ok) begin
              if (rate_acc > lcp_pkg::RATE_MAX) begin
                rate_ok_next = 1'b0;
              end else begin
                rate_val_next = rate_acc[13:0];
              end
            end
          end
          idx_next   = idx + 1'b1;
          state_next = ST_RD;
        end
      end

      ST_FIN: begin
        res_next = '{event_res: lcp_pkg::EV_UNKNOWN, led_cmd: lcp_pkg::LED_NONE,
                     rate_value: 14'd0};
        if (exact_hit[lcp_pkg::P_HELP]) begin
          res_next.event_res = lcp_pkg::EV_HELP;
        end else if (exact_hit[lcp_pkg::P_STATUS]) begin
          res_next.event_res = lcp_pkg::EV_STATUS;
        end else if (exact_hit[lcp_pkg::P_LED_ON]) begin
          res_next.event_res = lcp_pkg::EV_LED;
          res_next.led_cmd   = lcp_pkg::LED_ON;
        end else if (exact_hit[lcp_pkg::P_LED_OFF]) begin
          res_next.event_res = lcp_pkg::EV_LED;
          res_next.led_cmd   = lcp_pkg::LED_OFF;
        end else if (exact_hit[lcp_pkg::P_LED_TOG]) begin
          res_next.event_res = lcp_pkg::EV_LED;
          res_next.led_cmd   = lcp_pkg::LED_TOGGLE;
        end else if (prefix_hit[lcp_pkg::P_LED_SP] || exact_hit[lcp_pkg::P_LED]) begin
          res_next.event_res = lcp_pkg::EV_MALFORMED;
        end else if (prefix_hit[lcp_pkg::P_RATE_SP]) begin
          // At least one digit, every one a digit, and a value in range.
          if ((idx > lcp_pkg::CNT_W'(lcp_pkg::RATE_FIRST)) && rate_ok && (rate_val != 14'd0)) begin
            res_next.event_res  = lcp_pkg::EV_RATE;
            res_next.rate_value = rate_val;
          end else begin
            res_next.event_res = lcp_pkg::EV_MALFORMED;
          end
        end else if (exact_hit[lcp_pkg::P_RATE]) begin
          res_next.event_res = lcp_pkg::EV_MALFORMED;
        end
        line_count_next   = '0;
        active_flag_next  = 1'b0;
        discard_flag_next = 1'b0;
        state_next        = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      timeout_limit <= 32'd0;
      line_count    <= '0;
      last_tick     <= 32'd0;
      active_flag   <= 1'b0;
      discard_flag  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      line_count   <= line_count_next;
      last_tick    <= last_tick_next;
      active_flag  <= active_flag_next;
      discard_flag <= discard_flag_next;
      if (cfg_we) begin
        timeout_limit <= cfg_wdata;
      end
      // The output register loads when the pending result moves out of OUT.
      if ((state == ST_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_item;
    end
    res      <= res_next;
    idx      <= idx_next;
    match    <= match_next;
    rate_val <= rate_val_next;
    rate_ok  <= rate_ok_next;
    if ((state == ST_OUT) && (!out_valid || out_ready)) begin
      out_item <= res;
    end
  end

endmodule

/* rtl/core/lcp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
